// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, not checked while reset is active.
`define CTP_ASSERT_RST(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Clocked property that also holds while reset is active.
`define CTP_ASSERT_CLK(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/ctp_pkg.sv -----
// ----------------------------------------------------------------------------
// ctp_pkg
// Shared constants, types and the arctangent table of the polar converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ctp_pkg;

	localparam int DEF_COORD_WIDTH  = 16;
	localparam int DEF_ITERATIONS   = 16;

	localparam int PRESHIFT         = 30;   // magnitudes enter the rotator scaled by 2^30
	localparam int GUARD_BITS       = 3;    // vector growth and sign
	localparam int ZACC_W           = 28;   // angle accumulator, 2^-20 degree units
	localparam int ANGLE_FRAC_SHIFT = 13;
	localparam int RIGHT_ANGLE      = 11520;
	localparam int RIGHT_ANGLE_FINE = 94371840;
	localparam int RADIUS_W         = 16;
	localparam int ANGLE_W          = 15;

	typedef struct packed {
		logic x_neg;
		logic y_neg;
		logic x_zero;
		logic y_zero;
	} ctp_flags_t;

	// number of iteration stages: rotator steps and root bits share stages
	function automatic int stage_count(input int coord_width, input int iterations);
		int n;
		n = (coord_width > iterations) ? coord_width : iterations;
		return n;
	endfunction

	// atan(2^-i) in degrees, scaled by 2^20, rounded
	function automatic logic signed [ZACC_W-1:0] atan_entry(input int idx);
		logic signed [ZACC_W-1:0] v;
		case (idx)
			0:  v = ZACC_W'(47185920);
			1:  v = ZACC_W'(27855475);
			2:  v = ZACC_W'(14718068);
			3:  v = ZACC_W'(7471121);
			4:  v = ZACC_W'(3750058);
			5:  v = ZACC_W'(1876857);
			6:  v = ZACC_W'(938658);
			7:  v = ZACC_W'(469357);
			8:  v = ZACC_W'(234682);
			9:  v = ZACC_W'(117342);
			10: v = ZACC_W'(58671);
			11: v = ZACC_W'(29335);
			12: v = ZACC_W'(14668);
			13: v = ZACC_W'(7334);
			14: v = ZACC_W'(3667);
			15: v = ZACC_W'(1833);
			16: v = ZACC_W'(917);
			17: v = ZACC_W'(458);
			18: v = ZACC_W'(229);
			19: v = ZACC_W'(115);
			20: v = ZACC_W'(57);
			21: v = ZACC_W'(29);
			22: v = ZACC_W'(14);
			23: v = ZACC_W'(7);
			24: v = ZACC_W'(4);
			25: v = ZACC_W'(2);
			26: v = ZACC_W'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/ctp_point_if.sv -----
// ----------------------------------------------------------------------------
// ctp_point_if
// Request channel: one Cartesian point per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctp_point_if import ctp_pkg::*; #(
	parameter int COORD_WIDTH = DEF_COORD_WIDTH
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] x_coord;
	logic signed [COORD_WIDTH-1:0] y_coord;

	modport source (output valid, output x_coord, output y_coord, input ready);
	modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

`default_nettype wire

// ----- rtl/ctp_polar_if.sv -----
// ----------------------------------------------------------------------------
// ctp_polar_if
// Result channel: radius and folded angle per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctp_polar_if import ctp_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic [RADIUS_W-1:0]       radius;
	logic signed [ANGLE_W-1:0] angle_deg;

	modport source (output valid, output radius, output angle_deg, input ready);
	modport sink   (input valid, input radius, input angle_deg, output ready);
endinterface

`default_nettype wire

// ----- rtl/ctp_prep.sv -----
// ----------------------------------------------------------------------------
// ctp_prep
// Front stages: magnitudes, sign and zero flags, squares, sum of squares.
// ----------------------------------------------------------------------------
`default_nettype none

module ctp_prep import ctp_pkg::*; #(
	parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           en,
	input  logic                                           valid,
	input  logic signed [COORD_WIDTH-1:0]                  x_coord,
	input  logic signed [COORD_WIDTH-1:0]                  y_coord,
	output logic                                           valid_s3,
	output ctp_flags_t                                     flags_s3,
	output logic [2*COORD_WIDTH-1:0]                       sum_s3,
	output logic signed [COORD_WIDTH+PRESHIFT+GUARD_BITS-1:0] a,
	output logic signed [COORD_WIDTH+PRESHIFT+GUARD_BITS-1:0] b
);
	localparam int W  = COORD_WIDTH;
	localparam int SW = 2 * COORD_WIDTH;
	localparam int CW = COORD_WIDTH + PRESHIFT + GUARD_BITS;

	logic [W-1:0]  ax_c, ay_c;
	ctp_flags_t    flags_c;

	logic          valid_s1, valid_s2;
	ctp_flags_t    flags_s1, flags_s2;
	logic [W-1:0]  ax_s1, ay_s1, ax_s2, ay_s2, ax_s3, ay_s3;
	logic [SW-1:0] sqx_s2, sqy_s2;

	// W-bit negation maps the most negative value onto 2^(W-1) unsigned
	always_comb begin
		ax_c           = x_coord[W-1] ? W'(-x_coord) : W'(x_coord);
		ay_c           = y_coord[W-1] ? W'(-y_coord) : W'(y_coord);
		flags_c.x_neg  = x_coord[W-1];
		flags_c.y_neg  = y_coord[W-1];
		flags_c.x_zero = (x_coord == '0);
		flags_c.y_zero = (y_coord == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1    <= ax_c;
			ay_s1    <= ay_c;
			flags_s1 <= flags_c;

			sqx_s2   <= SW'(ax_s1) * SW'(ax_s1);
			sqy_s2   <= SW'(ay_s1) * SW'(ay_s1);
			ax_s2    <= ax_s1;
			ay_s2    <= ay_s1;
			flags_s2 <= flags_s1;

			sum_s3   <= sqx_s2 + sqy_s2;
			ax_s3    <= ax_s2;
			ay_s3    <= ay_s2;
			flags_s3 <= flags_s2;
		end
	end

	assign a = CW'({ax_s3, {PRESHIFT{1'b0}}});
	assign b = CW'({ay_s3, {PRESHIFT{1'b0}}});

endmodule

`default_nettype wire

// ----- rtl/ctp_stage.sv -----
// ----------------------------------------------------------------------------
// ctp_stage
// One iteration stage: a vectoring rotation step and one square-root bit.
// ----------------------------------------------------------------------------
`default_nettype none

module ctp_stage import ctp_pkg::*; #(
	parameter int COORD_WIDTH = DEF_COORD_WIDTH,
	parameter int ITERATIONS  = DEF_ITERATIONS,
	parameter int STAGE       = 0
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              en,
	input  logic                                              valid,
	input  ctp_flags_t                                        flags,
	input  logic signed [COORD_WIDTH+PRESHIFT+GUARD_BITS-1:0] a,
	input  logic signed [COORD_WIDTH+PRESHIFT+GUARD_BITS-1:0] b,
	input  logic signed [ZACC_W-1:0]                          z,
	input  logic [2*COORD_WIDTH-1:0]                          root,
	input  logic [2*COORD_WIDTH-1:0]                          rem,
	output logic                                              valid_sn,
	output ctp_flags_t                                        flags_sn,
	output logic signed [COORD_WIDTH+PRESHIFT+GUARD_BITS-1:0] a_sn,
	output logic signed [COORD_WIDTH+PRESHIFT+GUARD_BITS-1:0] b_sn,
	output logic signed [ZACC_W-1:0]                          z_sn,
	output logic [2*COORD_WIDTH-1:0]                          root_sn,
	output logic [2*COORD_WIDTH-1:0]                          rem_sn
);
	localparam int CW      = COORD_WIDTH + PRESHIFT + GUARD_BITS;
	localparam int SW      = 2 * COORD_WIDTH;
	localparam int RW      = COORD_WIDTH;
	localparam bit DO_ROT  = (STAGE < ITERATIONS);
	localparam bit DO_SQRT = (STAGE < RW);
	localparam int SQ_POS  = DO_SQRT ? 2 * (RW - 1 - STAGE) : 0;

	localparam logic signed [ZACC_W-1:0] ATAN_K = DO_ROT ? atan_entry(STAGE) : '0;
	localparam logic [SW-1:0]            SQ_BIT = DO_SQRT ? (SW'(1) << SQ_POS) : '0;

	logic signed [CW-1:0]     da, db, a_nx, b_nx;
	logic signed [ZACC_W-1:0] z_nx;
	logic [SW:0]              trial;
	logic [SW-1:0]            root_nx, rem_nx;

	always_comb begin
		// arithmetic shift rounds toward minus infinity
		da   = b >>> STAGE;
		db   = a >>> STAGE;
		a_nx = a;
		b_nx = b;
		z_nx = z;
		if (DO_ROT) begin
			if (!b[CW-1]) begin
				a_nx = a + da;
				b_nx = b - db;
				z_nx = z + ATAN_K;
			end else begin
				a_nx = a - da;
				b_nx = b + db;
				z_nx = z - ATAN_K;
			end
		end

		// restoring square root, one result bit
		trial   = {1'b0, root} + {1'b0, SQ_BIT};
		root_nx = root;
		rem_nx  = rem;
		if (DO_SQRT) begin
			if ({1'b0, rem} >= trial) begin
				rem_nx  = rem - trial[SW-1:0];
				root_nx = (root >> 1) + SQ_BIT;
			end else begin
				root_nx = root >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else if (en) begin
			valid_sn <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_sn <= flags;
			a_sn     <= a_nx;
			b_sn     <= b_nx;
			z_sn     <= z_nx;
			root_sn  <= root_nx;
			rem_sn   <= rem_nx;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/ctp_finish.sv -----
// ----------------------------------------------------------------------------
// ctp_finish
// Root rounding, angle clamp and rounding, quadrant folding, axis cases.
// ----------------------------------------------------------------------------
`default_nettype none

module ctp_finish import ctp_pkg::*; #(
	parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
	input  ctp_flags_t                flags,
	input  logic signed [ZACC_W-1:0]  z,
	input  logic [2*COORD_WIDTH-1:0]  root,
	input  logic [2*COORD_WIDTH-1:0]  rem,
	output logic [RADIUS_W-1:0]       radius,
	output logic signed [ANGLE_W-1:0] angle_deg
);
	localparam int RW = COORD_WIDTH;

	localparam logic signed [ZACC_W-1:0]  FINE_MAX = ZACC_W'(RIGHT_ANGLE_FINE);
	localparam logic signed [ZACC_W-1:0]  HALF_LSB = ZACC_W'(1 << (ANGLE_FRAC_SHIFT - 1));
	localparam logic signed [ANGLE_W-1:0] ANG_MAX  = ANGLE_W'(RIGHT_ANGLE);

	logic [RW:0]                rnd;
	logic signed [ZACC_W-1:0]   zc, zr;
	logic signed [ANGLE_W-1:0]  mag;

	always_comb begin
		// round to nearest: remainder above root means past the half point
		rnd    = (RW+1)'(root[RW-1:0]) + (RW+1)'(rem > root);
		radius = RADIUS_W'(rnd);

		zc = z;
		if (z < 0) begin
			zc = '0;
		end else if (z > FINE_MAX) begin
			zc = FINE_MAX;
		end
		zr  = (zc + HALF_LSB) >>> ANGLE_FRAC_SHIFT;
		mag = ANGLE_W'(zr);
		if (mag > ANG_MAX) begin
			mag = ANG_MAX;
		end

		if (flags.x_zero) begin
			if (flags.y_zero) begin
				angle_deg = '0;
			end else if (flags.y_neg) begin
				angle_deg = -ANG_MAX;
			end else begin
				angle_deg = ANG_MAX;
			end
		end else if (flags.y_zero) begin
			angle_deg = '0;
		end else if (flags.x_neg ^ flags.y_neg) begin
			angle_deg = -mag;
		end else begin
			angle_deg = mag;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/ctp_outbuf.sv -----
// ----------------------------------------------------------------------------
// ctp_outbuf
// Output register plus one spare entry; freezes the pipeline when full.
// ----------------------------------------------------------------------------
`default_nettype none

module ctp_outbuf import ctp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid,
	input  logic [RADIUS_W-1:0]       radius,
	input  logic signed [ANGLE_W-1:0] angle_deg,
	input  logic                      ready,
	output logic                      room,
	output logic                      valid_q,
	output logic [RADIUS_W-1:0]       radius_q,
	output logic signed [ANGLE_W-1:0] angle_q
);
	logic                      spare_v_q;
	logic [RADIUS_W-1:0]       spare_radius_q;
	logic signed [ANGLE_W-1:0] spare_angle_q;
	logic                      fire;

	assign fire = valid_q & ready;
	assign room = ~spare_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			spare_v_q <= 1'b0;
		end else if (spare_v_q) begin
			if (fire) begin
				spare_v_q <= 1'b0;
			end
		end else if (!valid_q || fire) begin
			valid_q <= valid;
		end else if (valid) begin
			spare_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (spare_v_q) begin
			if (fire) begin
				radius_q <= spare_radius_q;
				angle_q  <= spare_angle_q;
			end
		end else if (!valid_q || fire) begin
			if (valid) begin
				radius_q <= radius;
				angle_q  <= angle_deg;
			end
		end else if (valid) begin
			spare_radius_q <= radius;
			spare_angle_q  <= angle_deg;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/cartesian_to_polar_top.sv -----
// ----------------------------------------------------------------------------
// cartesian_to_polar_top
// Converts a signed fixed-point point (x, y), 8 fraction bits, into its
// radius sqrt(x*x + y*y) in the same units, rounded to nearest, and the angle
// atan(y/x) in 1/128 degree, folded into -90..+90 degrees. On the y axis the
// angle is +90 or -90 degrees by the sign of y, and 0 at the origin. The block
// is a fully pipelined unit with no state between requests: it takes one
// request every clock while the spare entry is free and returns results in
// request order, one per request. A request passes three front stages
// (magnitudes, squares, sum), one iteration stage per rotation step or root
// bit, whichever are more, in which a vectoring rotation step and one bit of
// the integer square root run side by side, and the output register. The
// output register has a spare entry behind it, so a stalled result does not
// block the input until the spare is also occupied; ready comes from a flop.
// ITERATIONS (8..32) sets the rotation steps and COORD_WIDTH (8..32) the
// coordinate width; the radius keeps its low 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module cartesian_to_polar_top import ctp_pkg::*; #(
	parameter int COORD_WIDTH = DEF_COORD_WIDTH,
	parameter int ITERATIONS  = DEF_ITERATIONS
) (
	input  logic         clk,
	input  logic         arst_n,
	ctp_point_if.sink    point,
	ctp_polar_if.source  polar
);
	localparam int NIT = stage_count(COORD_WIDTH, ITERATIONS);
	localparam int CW  = COORD_WIDTH + PRESHIFT + GUARD_BITS;
	localparam int SW  = 2 * COORD_WIDTH;

	// global advance: the whole pipeline moves unless the spare is occupied
	logic room;

	// stage-to-stage links, index 0 is the output of the front stages
	logic                     valid_c [NIT+1];
	ctp_flags_t               flags_c [NIT+1];
	logic signed [CW-1:0]     a_c     [NIT+1];
	logic signed [CW-1:0]     b_c     [NIT+1];
	logic signed [ZACC_W-1:0] z_c     [NIT+1];
	logic [SW-1:0]            root_c  [NIT+1];
	logic [SW-1:0]            rem_c   [NIT+1];

	logic [RADIUS_W-1:0]       fin_radius;
	logic signed [ANGLE_W-1:0] fin_angle;

	assign point.ready = room;

	ctp_prep #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (room),
		.valid    (point.valid),
		.x_coord  (point.x_coord),
		.y_coord  (point.y_coord),
		.valid_s3 (valid_c[0]),
		.flags_s3 (flags_c[0]),
		.sum_s3   (rem_c[0]),
		.a        (a_c[0]),
		.b        (b_c[0])
	);

	// angle accumulator and root start from zero; remainder starts as the sum
	assign z_c[0]    = '0;
	assign root_c[0] = '0;

	for (genvar k = 0; k < NIT; k++) begin : g_stage
		ctp_stage #(
			.COORD_WIDTH (COORD_WIDTH),
			.ITERATIONS  (ITERATIONS),
			.STAGE       (k)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (room),
			.valid    (valid_c[k]),
			.flags    (flags_c[k]),
			.a        (a_c[k]),
			.b        (b_c[k]),
			.z        (z_c[k]),
			.root     (root_c[k]),
			.rem      (rem_c[k]),
			.valid_sn (valid_c[k+1]),
			.flags_sn (flags_c[k+1]),
			.a_sn     (a_c[k+1]),
			.b_sn     (b_c[k+1]),
			.z_sn     (z_c[k+1]),
			.root_sn  (root_c[k+1]),
			.rem_sn   (rem_c[k+1])
		);
	end

	// the rotated vector itself is not needed past the last stage
	ctp_finish #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_finish (
		.flags     (flags_c[NIT]),
		.z         (z_c[NIT]),
		.root      (root_c[NIT]),
		.rem       (rem_c[NIT]),
		.radius    (fin_radius),
		.angle_deg (fin_angle)
	);

	ctp_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (valid_c[NIT]),
		.radius    (fin_radius),
		.angle_deg (fin_angle),
		.ready     (polar.ready),
		.room      (room),
		.valid_q   (polar.valid),
		.radius_q  (polar.radius),
		.angle_q   (polar.angle_deg)
	);

endmodule

`default_nettype wire

// ----- rtl/ctp_checker.sv -----
// ----------------------------------------------------------------------------
// ctp_checker
// Port-level checks of the polar converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ctp_checker import ctp_pkg::*; #(
	parameter int COORD_WIDTH = DEF_COORD_WIDTH,
	parameter int ITERATIONS  = DEF_ITERATIONS
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      point_valid,
	input logic                      point_ready,
	input logic                      polar_valid,
	input logic                      polar_ready,
	input logic [RADIUS_W-1:0]       radius,
	input logic signed [ANGLE_W-1:0] angle_deg
);
	// front stages, iteration stages, output register and spare
	localparam int MAX_FLIGHT = stage_count(COORD_WIDTH, ITERATIONS) + 5;
	localparam int CNT_W      = $clog2(MAX_FLIGHT + 1) + 1;

	localparam logic signed [ANGLE_W-1:0] ANG_MAX = ANGLE_W'(RIGHT_ANGLE);
	localparam logic signed [ANGLE_W-1:0] ANG_MIN = -ANG_MAX;

	logic [CNT_W-1:0] inflight_q;
	logic             in_fire, out_fire;

	assign in_fire  = point_valid & point_ready;
	assign out_fire = polar_valid & polar_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + CNT_W'(in_fire) - CNT_W'(out_fire);
		end
	end

	`CTP_ASSERT_CLK(a_reset_idle, clk, !arst_n |=> !polar_valid, "result shown during reset")
	`CTP_ASSERT_RST(a_no_phantom, clk, arst_n, polar_valid |-> inflight_q != '0, "result without request")
	`CTP_ASSERT_RST(a_depth, clk, arst_n, inflight_q <= CNT_W'(MAX_FLIGHT), "too many requests in flight")
	`CTP_ASSERT_RST(a_hold, clk, arst_n, polar_valid && !polar_ready |=> polar_valid && $stable(radius) && $stable(angle_deg), "stalled result changed")
	`CTP_ASSERT_CLK(a_angle_range, clk, polar_valid |-> angle_deg >= ANG_MIN && angle_deg <= ANG_MAX, "angle out of range")

endmodule

bind cartesian_to_polar_top ctp_checker #(
	.COORD_WIDTH (COORD_WIDTH),
	.ITERATIONS  (ITERATIONS)
) u_ctp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.point_valid (point.valid),
	.point_ready (point.ready),
	.polar_valid (polar.valid),
	.polar_ready (polar.ready),
	.radius      (polar.radius),
	.angle_deg   (polar.angle_deg)
);

`default_nettype wire
